// File: sv/lmfgr_pkg.sv
// Shared types, codes and font tables for the four-module LED matrix renderer.
// No dependencies; every other file of the block imports this package.
package lmfgr_pkg;

    localparam logic [1:0] REQ_PAIR    = 2'd0;
    localparam logic [1:0] REQ_YEAR    = 2'd1;
    localparam logic [1:0] REQ_WEEKDAY = 2'd2;

    localparam logic [3:0] GL_A = 4'd0;
    localparam logic [3:0] GL_D = 4'd1;
    localparam logic [3:0] GL_E = 4'd2;
    localparam logic [3:0] GL_F = 4'd3;
    localparam logic [3:0] GL_H = 4'd4;
    localparam logic [3:0] GL_I = 4'd5;
    localparam logic [3:0] GL_M = 4'd6;
    localparam logic [3:0] GL_N = 4'd7;
    localparam logic [3:0] GL_O = 4'd8;
    localparam logic [3:0] GL_R = 4'd9;
    localparam logic [3:0] GL_S = 4'd10;
    localparam logic [3:0] GL_T = 4'd11;
    localparam logic [3:0] GL_U = 4'd12;
    localparam logic [3:0] GL_W = 4'd13;

    localparam int unsigned NUM_MODULES = 4;
    localparam int unsigned IMAGE_W     = 64;

    typedef logic [IMAGE_W-1:0] t_image;
    typedef logic [2:0][3:0]    t_day_name;

    // One frame request with all digits resolved, entry 0 drives module 0.
    typedef struct packed {
        logic [1:0]                   req_type;
        logic [NUM_MODULES-1:0][3:0]  digit;
        logic [2:0]                   weekday;
        logic                         blank_enable;
        logic                         blank_second_pair;
    } t_frame;

    // Seven font rows in bytes 0..6, byte 7 empty.
    function automatic t_image digit_glyph(input logic [3:0] d);
        t_image img;
        case (d)
            4'd0:    img = 64'h000E_1119_1513_110E;
            4'd1:    img = 64'h000E_0404_0404_0C04;
            4'd2:    img = 64'h001F_1008_0601_110E;
            4'd3:    img = 64'h000E_1101_0204_021F;
            4'd4:    img = 64'h0002_021F_120A_0602;
            4'd5:    img = 64'h000E_1101_011E_101F;
            4'd6:    img = 64'h000E_1111_1E10_0806;
            4'd7:    img = 64'h0008_0808_0402_011F;
            4'd8:    img = 64'h000E_1111_0E11_110E;
            4'd9:    img = 64'h000C_0201_0F11_110E;
            default: img = '0;
        endcase
        return img;
    endfunction

    // Five font rows in bytes 1..5.
    function automatic t_image letter_glyph(input logic [3:0] g);
        t_image img;
        case (g)
            GL_A:    img = 64'h0000_1111_1F11_0E00;
            GL_D:    img = 64'h0000_1E11_1111_1E00;
            GL_E:    img = 64'h0000_1F10_1E10_1F00;
            GL_F:    img = 64'h0000_1010_1E10_1F00;
            GL_H:    img = 64'h0000_1111_1F11_1100;
            GL_I:    img = 64'h0000_0E04_0404_0E00;
            GL_M:    img = 64'h0000_1111_151B_1100;
            GL_N:    img = 64'h0000_1113_1519_1100;
            GL_O:    img = 64'h0000_0E11_1111_0E00;
            GL_R:    img = 64'h0000_1112_1E11_1E00;
            GL_S:    img = 64'h0000_1E01_0E10_0F00;
            GL_T:    img = 64'h0000_0404_0404_1F00;
            GL_U:    img = 64'h0000_0E11_1111_1100;
            GL_W:    img = 64'h0000_111B_1511_1100;
            default: img = 64'h0000_1111_1F11_0E00;
        endcase
        return img;
    endfunction

    // Entry 0 is the leftmost letter.
    function automatic t_day_name day_name(input logic [2:0] wd);
        t_day_name n;
        case (wd)
            3'd1:    n = '{GL_N, GL_O, GL_M};
            3'd2:    n = '{GL_E, GL_U, GL_T};
            3'd3:    n = '{GL_D, GL_E, GL_W};
            3'd4:    n = '{GL_U, GL_H, GL_T};
            3'd5:    n = '{GL_I, GL_R, GL_F};
            3'd6:    n = '{GL_T, GL_A, GL_S};
            default: n = '{GL_N, GL_U, GL_S};
        endcase
        return n;
    endfunction

endpackage

// File: sv/lmfgr_frame.sv
// Frame assembly: turns resolved digits or a weekday into four module images.
// Depends on lmfgr_pkg for the font tables and the frame request type.
module lmfgr_frame (
    input  lmfgr_pkg::t_frame i_frame,
    output lmfgr_pkg::t_image o_module_0,
    output lmfgr_pkg::t_image o_module_1,
    output lmfgr_pkg::t_image o_module_2,
    output lmfgr_pkg::t_image o_module_3
);
    import lmfgr_pkg::*;

    t_image    digit_img [NUM_MODULES];
    t_image    img       [NUM_MODULES];
    t_day_name name;
    logic      blank_left;
    logic      blank_right;

    always_comb begin
        for (int k = 0; k < NUM_MODULES; k++) begin
            digit_img[k] = digit_glyph(i_frame.digit[k]);
        end
    end

    assign name        = day_name(i_frame.weekday);
    assign blank_left  = i_frame.blank_enable && !i_frame.blank_second_pair;
    assign blank_right = i_frame.blank_enable && i_frame.blank_second_pair;

    always_comb begin
        for (int k = 0; k < NUM_MODULES; k++) begin
            img[k] = '0;
        end
        case (i_frame.req_type)
            REQ_PAIR: begin
                img[0] = blank_left  ? '0 : digit_img[0];
                img[1] = blank_left  ? '0 : digit_img[1];
                img[2] = blank_right ? '0 : digit_img[2];
                img[3] = blank_right ? '0 : digit_img[3];
            end
            REQ_YEAR: begin
                for (int k = 0; k < NUM_MODULES; k++) begin
                    img[k] = digit_img[k];
                end
            end
            REQ_WEEKDAY: begin
                // rightmost module stays dark
                img[0] = letter_glyph(name[0]);
                img[1] = letter_glyph(name[1]);
                img[2] = letter_glyph(name[2]);
            end
            default: begin
                img[0] = '0;
            end
        endcase
    end

    assign o_module_0 = img[0];
    assign o_module_1 = img[1];
    assign o_module_2 = img[2];
    assign o_module_3 = img[3];

endmodule

// File: sv/led_matrix_four_glyph_renderer.sv
// Four-module LED matrix frame renderer, top level with the digit split pipeline.
// Depends on lmfgr_pkg and lmfgr_frame.
// Pipeline: 4 register stages (stage 1, stage 2, stage 3 frame request, stage 4 images);
// an accepted item moves through them in order, and o_valid is the stage 4 valid bit.
// Throughput: one item per cycle; a stall holds the full stages and lets items close up.
// Reset (synchronous, active low) clears all stage valid bits; no other state.
module led_matrix_four_glyph_renderer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_first_value,
    input  logic [6:0]  i_second_value,
    input  logic [13:0] i_year_value,
    input  logic [2:0]  i_weekday,
    input  logic        i_blank_enable,
    input  logic        i_blank_second_pair,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_module_0,
    output logic [63:0] o_module_1,
    output logic [63:0] o_module_2,
    output logic [63:0] o_module_3
);
    import lmfgr_pkg::*;

    // stage enables, back to front
    logic en1, en2, en3, en4;

    logic r_v1, r_v2, r_v3, r_v4;

    // stage 1: pair digits, year units and year / 10
    logic [1:0]  r1_req;
    logic [3:0]  r1_a_tens, r1_a_units, r1_b_tens, r1_b_units;
    logic [3:0]  r1_y_units;
    logic [10:0] r1_q10;
    logic [2:0]  r1_wd;
    logic        r1_blank, r1_second;

    // stage 2: year tens and year / 100
    logic [1:0]  r2_req;
    logic [3:0]  r2_a_tens, r2_a_units, r2_b_tens, r2_b_units;
    logic [3:0]  r2_y_units, r2_y_tens;
    logic [7:0]  r2_q100;
    logic [2:0]  r2_wd;
    logic        r2_blank, r2_second;

    // stage 3: resolved frame request
    t_frame r3_frame;

    // stage 4: output images
    t_image r_module_0, r_module_1, r_module_2, r_module_3;

    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // ---- stage 1 arithmetic: x*205 >> 11 is x/10 for x below 1029
    logic [14:0] a_prod, b_prod;
    logic [3:0]  a_q, b_q;
    logic [6:0]  a_rem, b_rem;
    logic [3:0]  n_a_tens, n_b_tens;
    logic [29:0] y_prod;
    logic [10:0] n_q10;
    logic [13:0] y_rem;

    assign a_prod   = 15'(i_first_value) * 15'd205;
    assign b_prod   = 15'(i_second_value) * 15'd205;
    assign a_q      = a_prod[14:11];
    assign b_q      = b_prod[14:11];
    assign a_rem    = i_first_value - 7'(a_q) * 7'd10;
    assign b_rem    = i_second_value - 7'(b_q) * 7'd10;
    assign n_a_tens = (a_q >= 4'd10) ? a_q - 4'd10 : a_q;
    assign n_b_tens = (b_q >= 4'd10) ? b_q - 4'd10 : b_q;
    // x*52429 >> 19 is x/10 for every 16-bit x
    assign y_prod   = 30'(i_year_value) * 30'd52429;
    assign n_q10    = y_prod[29:19];
    assign y_rem    = i_year_value - 14'(n_q10) * 14'd10;

    // ---- stage 2 arithmetic
    logic [26:0] q10_prod;
    logic [7:0]  n_q100;
    logic [10:0] q10_rem;

    assign q10_prod = 27'(r1_q10) * 27'd52429;
    assign n_q100   = q10_prod[26:19];
    assign q10_rem  = r1_q10 - 11'(n_q100) * 11'd10;

    // ---- stage 3 arithmetic
    logic [15:0] q100_prod;
    logic [4:0]  q1000;
    logic [7:0]  q100_rem;
    logic [3:0]  n_thousands;
    t_frame      n_frame;

    assign q100_prod   = 16'(r2_q100) * 16'd205;
    assign q1000       = q100_prod[15:11];
    assign q100_rem    = r2_q100 - 8'(q1000) * 8'd10;
    assign n_thousands = (q1000 >= 5'd10) ? 4'(q1000 - 5'd10) : q1000[3:0];

    always_comb begin
        n_frame.req_type          = r2_req;
        n_frame.weekday           = r2_wd;
        n_frame.blank_enable      = r2_blank;
        n_frame.blank_second_pair = r2_second;
        if (r2_req == REQ_YEAR) begin
            n_frame.digit[0] = n_thousands;
            n_frame.digit[1] = q100_rem[3:0];
            n_frame.digit[2] = r2_y_tens;
            n_frame.digit[3] = r2_y_units;
        end else begin
            n_frame.digit[0] = r2_a_tens;
            n_frame.digit[1] = r2_a_units;
            n_frame.digit[2] = r2_b_tens;
            n_frame.digit[3] = r2_b_units;
        end
    end

    // ---- stage 4 glyph lookup
    t_image n_module_0, n_module_1, n_module_2, n_module_3;

    lmfgr_frame u_frame (
        .i_frame    (r3_frame),
        .o_module_0 (n_module_0),
        .o_module_1 (n_module_1),
        .o_module_2 (n_module_2),
        .o_module_3 (n_module_3)
    );

    // ---- valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // ---- payload, held while the stage is stalled
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_req     <= i_req_type;
            r1_a_tens  <= n_a_tens;
            r1_a_units <= a_rem[3:0];
            r1_b_tens  <= n_b_tens;
            r1_b_units <= b_rem[3:0];
            r1_y_units <= y_rem[3:0];
            r1_q10     <= n_q10;
            r1_wd      <= i_weekday;
            r1_blank   <= i_blank_enable;
            r1_second  <= i_blank_second_pair;
        end
        if (en2) begin
            r2_req     <= r1_req;
            r2_a_tens  <= r1_a_tens;
            r2_a_units <= r1_a_units;
            r2_b_tens  <= r1_b_tens;
            r2_b_units <= r1_b_units;
            r2_y_units <= r1_y_units;
            r2_y_tens  <= q10_rem[3:0];
            r2_q100    <= n_q100;
            r2_wd      <= r1_wd;
            r2_blank   <= r1_blank;
            r2_second  <= r1_second;
        end
        if (en3) begin
            r3_frame <= n_frame;
        end
        if (en4) begin
            r_module_0 <= n_module_0;
            r_module_1 <= n_module_1;
            r_module_2 <= n_module_2;
            r_module_3 <= n_module_3;
        end
    end

    assign o_valid    = r_v4;
    assign o_module_0 = r_module_0;
    assign o_module_1 = r_module_1;
    assign o_module_2 = r_module_2;
    assign o_module_3 = r_module_3;

endmodule
